/* hdl/rsa_pkg.sv */
// ----------------------------------------------------------------------------
// rsa_pkg
// Shared constants and types of the refcounted slot allocator.
// ----------------------------------------------------------------------------
package rsa_pkg;

	localparam int NUM_SLOTS  = 256;
	localparam int COUNT_BITS = 16;
	localparam int IDX_BITS   = 8;
	localparam int DEPTH_BITS = IDX_BITS + 1;
	localparam int TOTAL_BITS = 32;

	typedef enum logic {
		MODE_ADD    = 1'b0,
		MODE_REMOVE = 1'b1
	} mode_t;

	typedef logic [IDX_BITS-1:0]   idx_t;
	typedef logic [COUNT_BITS-1:0] count_t;
	typedef logic [DEPTH_BITS-1:0] depth_t;

	typedef struct packed {
		logic   en;
		idx_t   addr;
		count_t data;
	} count_wr_t;

	typedef struct packed {
		logic push;
		logic pop;
		idx_t idx;
	} stack_op_t;

endpackage

/* hdl/rsa_req_if.sv */
// ----------------------------------------------------------------------------
// rsa_req_if
// Request channel: mode and slot index with valid/ready handshake.
// ----------------------------------------------------------------------------
interface rsa_req_if;
	logic                   valid;
	logic                   ready;
	logic                   mode;
	logic [rsa_pkg::IDX_BITS-1:0] slot_index;

	modport source (output valid, output mode, output slot_index, input ready);
	modport sink   (input valid, input mode, input slot_index, output ready);
endinterface

/* hdl/rsa_rsp_if.sv */
// ----------------------------------------------------------------------------
// rsa_rsp_if
// Response channel: status and running totals with valid/ready handshake.
// ----------------------------------------------------------------------------
interface rsa_rsp_if;
	logic        valid;
	logic        ready;
	logic        slot_changed;
	logic [8:0]  occupied_slots;
	logic [31:0] total_tokens;
	logic        error;

	modport source (output valid, output slot_changed, output occupied_slots,
		output total_tokens, output error, input ready);
	modport sink   (input valid, input slot_changed, input occupied_slots,
		input total_tokens, input error, output ready);
endinterface

/* hdl/refcounted_slot_allocator.sv */
// ----------------------------------------------------------------------------
// refcounted_slot_allocator
// Slot allocator with per-slot reference counts and a free-index stack.
//
// Channels: req carries mode (add or remove a token) and slot_index; rsp
// returns slot_changed, occupied_slots, total_tokens and error, one
// transaction per request.
// Timing: a request reads the count and stack RAMs at the edge that accepts
// it; the result is registered in the output register once that register
// is free, which raises rsp.valid.
// Requests: none is taken while the previous one is in the RAM read and
// modify-write-back of the same entry; the next request is taken as soon
// as the previous one has written back, even while its result waits.
// Reset: all counts read as zero (per-entry valid bits), totals and stack
// depth clear; no clearing pass, requests are taken right after reset.
// Stall: while rsp.ready is low the result holds; one further request may
// be read and then waits until the output register frees.
// Invalid requests return error=1 with unchanged totals and change nothing.
// ----------------------------------------------------------------------------
module refcounted_slot_allocator (
	input logic      clk,
	input logic      arst_n,
	rsa_req_if.sink  req,
	rsa_rsp_if.source rsp
);

	logic                s1_valid_q;
	logic                mode_s1;
	rsa_pkg::idx_t       idx_s1;
	logic                out_valid_q;
	logic                changed_q;
	logic                err_q;
	logic [8:0]          occ_q;
	logic [31:0]         total_q;

	logic                accept;
	logic                s1_fire;
	rsa_pkg::count_t     cnt;
	rsa_pkg::idx_t       top_idx;
	rsa_pkg::depth_t     depth;
	logic [9:0]          fresh;
	logic                on_top;
	logic                cnt_zero;
	logic                cnt_one;
	logic                is_add;
	logic                err;
	logic                changed;
	rsa_pkg::count_wr_t  cwr;
	rsa_pkg::stack_op_t  sop;

	assign accept     = req.valid && req.ready;
	assign req.ready  = !s1_valid_q;
	assign s1_fire    = s1_valid_q && (!out_valid_q || rsp.ready);

	rsa_count_store u_count (
		.clk     (clk),
		.arst_n  (arst_n),
		.rd_en   (accept),
		.rd_addr (req.slot_index),
		.rd_data (cnt),
		.wr      (cwr)
	);

	rsa_free_stack u_stack (
		.clk     (clk),
		.arst_n  (arst_n),
		.rd_en   (accept),
		.op      (sop),
		.top_idx (top_idx),
		.depth   (depth)
	);

	always_comb begin
		is_add   = (rsa_pkg::mode_t'(mode_s1) == rsa_pkg::MODE_ADD);
		cnt_zero = (cnt == '0);
		cnt_one  = (cnt == rsa_pkg::COUNT_BITS'(1));
		fresh    = {1'b0, occ_q} + {1'b0, depth};
		on_top   = (depth != '0) && (top_idx == idx_s1);
		if (is_add) begin
			err = ({2'b00, idx_s1} > fresh) ||
				(cnt_zero && !on_top && ({2'b00, idx_s1} != fresh)) ||
				(cnt == {rsa_pkg::COUNT_BITS{1'b1}}) ||
				(total_q == 32'hFFFF_FFFF);
			changed = !err && cnt_zero;
		end else begin
			err     = cnt_zero;
			changed = !err && cnt_one;
		end

		cwr.en   = s1_fire && !err;
		cwr.addr = idx_s1;
		cwr.data = is_add ? cnt + rsa_pkg::COUNT_BITS'(1) : cnt - rsa_pkg::COUNT_BITS'(1);

		sop.push = s1_fire && !is_add && changed;
		sop.pop  = s1_fire && is_add && changed && on_top;
		sop.idx  = idx_s1;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			s1_valid_q  <= 1'b0;
			out_valid_q <= 1'b0;
			occ_q       <= '0;
			total_q     <= '0;
		end else begin
			if (accept) begin
				s1_valid_q <= 1'b1;
			end else if (s1_fire) begin
				s1_valid_q <= 1'b0;
			end
			if (s1_fire) begin
				out_valid_q <= 1'b1;
			end else if (rsp.ready) begin
				out_valid_q <= 1'b0;
			end
			if (s1_fire && !err) begin
				total_q <= is_add ? total_q + 32'd1 : total_q - 32'd1;
				if (changed) begin
					occ_q <= is_add ? occ_q + 9'd1 : occ_q - 9'd1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			mode_s1 <= req.mode;
			idx_s1  <= req.slot_index;
		end
		if (s1_fire) begin
			changed_q <= changed;
			err_q     <= err;
		end
	end

	assign rsp.valid          = out_valid_q;
	assign rsp.slot_changed   = changed_q;
	assign rsp.error          = err_q;
	assign rsp.occupied_slots = occ_q;
	assign rsp.total_tokens   = total_q;

endmodule

/* hdl/rsa_count_store.sv */
// ----------------------------------------------------------------------------
// rsa_count_store
// Per-slot token counts in a synchronous RAM; valid bits make unwritten
// entries read as zero after reset.
// ----------------------------------------------------------------------------
module rsa_count_store (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               rd_en,
	input  rsa_pkg::idx_t      rd_addr,
	output rsa_pkg::count_t    rd_data,
	input  rsa_pkg::count_wr_t wr
);

	rsa_pkg::count_t mem [rsa_pkg::NUM_SLOTS];
	logic            valid_q [rsa_pkg::NUM_SLOTS];
	rsa_pkg::count_t rd_q;
	logic            rd_valid_q;

	always_ff @(posedge clk) begin
		if (wr.en) begin
			mem[wr.addr] <= wr.data;
		end
		if (rd_en) begin
			rd_q <= mem[rd_addr];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < rsa_pkg::NUM_SLOTS; i++) begin
				valid_q[i] <= 1'b0;
			end
			rd_valid_q <= 1'b0;
		end else begin
			if (wr.en) begin
				valid_q[wr.addr] <= 1'b1;
			end
			if (rd_en) begin
				rd_valid_q <= valid_q[rd_addr];
			end
		end
	end

	assign rd_data = rd_valid_q ? rd_q : '0;

endmodule

/* hdl/rsa_free_stack.sv */
// ----------------------------------------------------------------------------
// rsa_free_stack
// Stack of freed slot indices in a synchronous RAM, with its depth counter.
// ----------------------------------------------------------------------------
module rsa_free_stack (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               rd_en,
	input  rsa_pkg::stack_op_t op,
	output rsa_pkg::idx_t      top_idx,
	output rsa_pkg::depth_t    depth
);

	rsa_pkg::idx_t   mem [rsa_pkg::NUM_SLOTS];
	rsa_pkg::idx_t   top_q;
	rsa_pkg::depth_t depth_q;
	rsa_pkg::depth_t depth_dec;
	logic            full;

	assign depth_dec = depth_q - rsa_pkg::DEPTH_BITS'(1);
	assign full      = depth_q[rsa_pkg::DEPTH_BITS-1];

	always_ff @(posedge clk) begin
		if (op.push && !full) begin
			mem[depth_q[rsa_pkg::IDX_BITS-1:0]] <= op.idx;
		end
		if (rd_en) begin
			top_q <= mem[depth_dec[rsa_pkg::IDX_BITS-1:0]];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			depth_q <= '0;
		end else if (op.push && !full) begin
			depth_q <= depth_q + rsa_pkg::DEPTH_BITS'(1);
		end else if (op.pop) begin
			depth_q <= depth_dec;
		end
	end

	assign top_idx = top_q;
	assign depth   = depth_q;

endmodule

/* hdl/rsa_checker.sv */
// ----------------------------------------------------------------------------
// rsa_checker
// Port-level checks of the slot allocator, bound to the top level.
// ----------------------------------------------------------------------------
module rsa_checker (
	input logic        clk,
	input logic        arst_n,
	input logic        req_valid,
	input logic        req_ready,
	input logic        rsp_valid,
	input logic        rsp_ready,
	input logic        slot_changed,
	input logic [8:0]  occupied_slots,
	input logic [31:0] total_tokens,
	input logic        error
);

	a_one_in_flight: assert property (@(posedge clk) disable iff (!arst_n)
		req_valid && req_ready |=> !req_ready)
		else $error("request accepted while previous one still in progress");

	a_error_no_change: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && error |-> !slot_changed)
		else $error("error transaction reports a slot change");

	a_occ_range: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid |-> occupied_slots <= 9'd256)
		else $error("occupied slot count out of range");

	a_rsp_hold: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && !rsp_ready |=> rsp_valid && $stable(total_tokens) &&
			$stable(occupied_slots))
		else $error("stalled response changed");

endmodule

bind refcounted_slot_allocator rsa_checker u_rsa_checker (
	.clk            (clk),
	.arst_n         (arst_n),
	.req_valid      (req.valid),
	.req_ready      (req.ready),
	.rsp_valid      (rsp.valid),
	.rsp_ready      (rsp.ready),
	.slot_changed   (rsp.slot_changed),
	.occupied_slots (rsp.occupied_slots),
	.total_tokens   (rsp.total_tokens),
	.error          (rsp.error)
);

/* tb/tb_top.sv */
// ----------------------------------------------------------------------------
// tb_top
// Self-checking testbench for refcounted_slot_allocator. A queue of add and
// remove transactions, filled up front, feeds a clocked driver with random
// gaps. A clocked monitor stalls the response channel at random and compares
// each result with the oldest prediction. The run covers opening every slot,
// emptying them all onto a full free stack, and random grow and shrink
// traffic mixed with invalid requests.
// ----------------------------------------------------------------------------
module tb_top;

	localparam logic PLAN_BOOK  = 1'b0;
	localparam logic CHECK_BOOK = 1'b1;
	localparam int CYCLE_LIMIT = 1500000;
	localparam int MAX_REPORTS = 40;

	typedef struct packed {
		rsa_pkg::mode_t mode;
		rsa_pkg::idx_t  idx;
		logic           quiet;
		logic [3:0]     gap;
	} req_item_t;

	typedef struct packed {
		logic        changed;
		logic [8:0]  occupied;
		logic [31:0] tokens;
		logic        err;
	} result_t;

	logic clk = 1'b0;
	logic arst_n;

	rsa_req_if req_ch ();
	rsa_rsp_if rsp_ch ();

	refcounted_slot_allocator DUT (
		.clk    (clk),
		.arst_n (arst_n),
		.req    (req_ch),
		.rsp    (rsp_ch)
	);

	always #6 clk = ~clk;

	// two copies of the allocator state: one steers stimulus, one checks
	rsa_pkg::count_t cnt_tbl   [2][rsa_pkg::NUM_SLOTS];
	rsa_pkg::idx_t   stk_tbl   [2][rsa_pkg::NUM_SLOTS];
	rsa_pkg::depth_t depth_tbl [2];
	rsa_pkg::depth_t occ_tbl   [2];
	logic [31:0]     tok_tbl   [2];

	req_item_t pending_reqs [$];
	result_t   due_results  [$];

	req_item_t cur_req;
	logic      have_req;
	int        gap_left;
	logic      rsp_quiet;
	int        stall_left;
	result_t   due;
	result_t   predicted;
	int        mismatches;
	int        n_results;
	int        n_rejected;
	int        n_opened;
	int        peak_occ;
	int        cycles;

	function automatic result_t apply_request(input logic book, input rsa_pkg::mode_t m,
		input rsa_pkg::idx_t ix);
		result_t         r;
		rsa_pkg::count_t c;
		int              fresh;
		logic            on_top;
		c = cnt_tbl[book][ix];
		r.changed = 1'b0;
		r.err = 1'b0;
		if (m == rsa_pkg::MODE_ADD) begin
			fresh = int'(occ_tbl[book]) + int'(depth_tbl[book]);
			on_top = depth_tbl[book] != 0 &&
				stk_tbl[book][rsa_pkg::idx_t'(depth_tbl[book] - 1'b1)] == ix;
			if (int'(ix) > fresh || (c == 0 && !on_top && int'(ix) != fresh) ||
				c == '1 || tok_tbl[book] == 32'hFFFF_FFFF) begin
				r.err = 1'b1;
			end else begin
				if (c == 0 && on_top)
					depth_tbl[book] = depth_tbl[book] - 1'b1;
				cnt_tbl[book][ix] = c + 1'b1;
				tok_tbl[book] = tok_tbl[book] + 1;
				if (c == 0) begin
					occ_tbl[book] = occ_tbl[book] + 1'b1;
					r.changed = 1'b1;
				end
			end
		end else if (c == 0) begin
			r.err = 1'b1;
		end else begin
			cnt_tbl[book][ix] = c - 1'b1;
			tok_tbl[book] = tok_tbl[book] - 1;
			if (c == 1) begin
				occ_tbl[book] = occ_tbl[book] - 1'b1;
				if (depth_tbl[book] < rsa_pkg::NUM_SLOTS) begin
					stk_tbl[book][rsa_pkg::idx_t'(depth_tbl[book])] = ix;
					depth_tbl[book] = depth_tbl[book] + 1'b1;
				end
				r.changed = 1'b1;
			end
		end
		r.occupied = occ_tbl[book];
		r.tokens = tok_tbl[book];
		return r;
	endfunction

	function automatic int plan_fresh();
		return int'(occ_tbl[PLAN_BOOK]) + int'(depth_tbl[PLAN_BOOK]);
	endfunction

	function automatic rsa_pkg::idx_t plan_top();
		return stk_tbl[PLAN_BOOK][rsa_pkg::idx_t'(depth_tbl[PLAN_BOOK] - 1'b1)];
	endfunction

	// scan from a random start for a slot with or without tokens
	function automatic rsa_pkg::idx_t find_slot(input logic want_busy);
		rsa_pkg::idx_t ix;
		ix = rsa_pkg::idx_t'($urandom_range(0, rsa_pkg::NUM_SLOTS - 1));
		while ((cnt_tbl[PLAN_BOOK][ix] != 0) != want_busy)
			ix = ix + 1'b1;
		return ix;
	endfunction

	task automatic send(input rsa_pkg::mode_t m, input rsa_pkg::idx_t ix, input logic quiet);
		req_item_t it;
		it.mode = m;
		it.idx = ix;
		it.quiet = quiet;
		it.gap = quiet ? 4'd0 : 4'($urandom_range(0, 15));
		void'(apply_request(PLAN_BOOK, m, ix));
		pending_reqs = {pending_reqs, it};
	endtask

	// open a closed slot: the top of the free stack or the next fresh index; with every slot open, add to a busy slot
	task automatic open_slot(input logic quiet);
		int fresh;
		fresh = plan_fresh();
		if (depth_tbl[PLAN_BOOK] != 0 &&
			(fresh >= rsa_pkg::NUM_SLOTS || $urandom_range(0, 1)))
			send(rsa_pkg::MODE_ADD, plan_top(), quiet);
		else if (fresh < rsa_pkg::NUM_SLOTS)
			send(rsa_pkg::MODE_ADD, rsa_pkg::idx_t'(fresh), quiet);
		else
			send(rsa_pkg::MODE_ADD, find_slot(1'b1), quiet);
	endtask

	task automatic random_request(input logic grow, input logic quiet);
		int pick;
		int fresh;
		pick = $urandom_range(0, 99);
		fresh = plan_fresh();
		if (pick < 5) begin
			send(rsa_pkg::mode_t'($urandom_range(0, 1)),
				rsa_pkg::idx_t'($urandom_range(0, rsa_pkg::NUM_SLOTS - 1)), quiet);
		end else if (pick < 7 && depth_tbl[PLAN_BOOK] >= 2) begin
			send(rsa_pkg::MODE_ADD, stk_tbl[PLAN_BOOK][
				rsa_pkg::idx_t'($urandom_range(0, depth_tbl[PLAN_BOOK] - 2))], quiet);
		end else if (pick < 9 && fresh < rsa_pkg::NUM_SLOTS - 1) begin
			send(rsa_pkg::MODE_ADD,
				rsa_pkg::idx_t'($urandom_range(fresh + 1, rsa_pkg::NUM_SLOTS - 1)), quiet);
		end else if (pick < 11 && occ_tbl[PLAN_BOOK] < rsa_pkg::NUM_SLOTS) begin
			send(rsa_pkg::MODE_REMOVE, find_slot(1'b0), quiet);
		end else if (pick < (grow ? 65 : 26)) begin
			open_slot(quiet);
		end else if (pick < (grow ? 85 : 46) && occ_tbl[PLAN_BOOK] != 0) begin
			send(rsa_pkg::MODE_ADD, find_slot(1'b1), quiet);
		end else if (occ_tbl[PLAN_BOOK] != 0) begin
			send(rsa_pkg::MODE_REMOVE, find_slot(1'b1), quiet);
		end else begin
			open_slot(quiet);
		end
	endtask

	task automatic report_mismatch(input string what);
		mismatches++;
		if (mismatches <= MAX_REPORTS)
			$display("MISMATCH @cycle %0d: %s", cycles, what);
	endtask

	// request driver
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			req_ch.valid <= 1'b0;
			req_ch.mode <= rsa_pkg::MODE_ADD;
			req_ch.slot_index <= '0;
			rsp_quiet <= 1'b0;
			have_req = 1'b0;
			gap_left = 0;
		end else begin
			if (req_ch.valid && req_ch.ready) begin
				predicted = apply_request(CHECK_BOOK, rsa_pkg::mode_t'(req_ch.mode),
					req_ch.slot_index);
				due_results = {due_results, predicted};
			end
			if (!req_ch.valid || req_ch.ready) begin
				if (!have_req && pending_reqs.size() != 0) begin
					cur_req = pending_reqs.pop_front();
					have_req = 1'b1;
					gap_left = int'(cur_req.gap);
				end
				if (have_req && gap_left == 0) begin
					req_ch.valid <= 1'b1;
					req_ch.mode <= cur_req.mode;
					req_ch.slot_index <= cur_req.idx;
					rsp_quiet <= cur_req.quiet;
					have_req = 1'b0;
				end else begin
					req_ch.valid <= 1'b0;
					if (have_req)
						gap_left--;
				end
			end
		end
	end

	// response monitor
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rsp_ch.ready <= 1'b0;
			stall_left = 0;
		end else begin
			if (rsp_ch.valid && rsp_ch.ready) begin
				n_results++;
				if (due_results.size() == 0) begin
					report_mismatch("result with no request outstanding");
				end else begin
					due = due_results.pop_front();
					if (rsp_ch.slot_changed !== due.changed)
						report_mismatch($sformatf("slot_changed %b, expected %b",
							rsp_ch.slot_changed, due.changed));
					if (rsp_ch.occupied_slots !== due.occupied)
						report_mismatch($sformatf("occupied_slots %0d, expected %0d",
							rsp_ch.occupied_slots, due.occupied));
					if (rsp_ch.total_tokens !== due.tokens)
						report_mismatch($sformatf("total_tokens %0d, expected %0d",
							rsp_ch.total_tokens, due.tokens));
					if (rsp_ch.error !== due.err)
						report_mismatch($sformatf("error %b, expected %b",
							rsp_ch.error, due.err));
					if (due.err)
						n_rejected++;
					if (due.changed)
						n_opened++;
					if (int'(due.occupied) > peak_occ)
						peak_occ = int'(due.occupied);
				end
				stall_left = rsp_quiet ? 0 : $urandom_range(0, 15);
			end
			if (stall_left > 0) begin
				rsp_ch.ready <= 1'b0;
				stall_left--;
			end else begin
				rsp_ch.ready <= 1'b1;
			end
		end
	end

	always @(posedge clk) begin
		cycles++;
		if (cycles >= CYCLE_LIMIT) begin
			$display("Timeout after %0d cycles", cycles);
			$display("Testbench completed WITH ERRORS");
			$finish;
		end
	end

	initial begin
		logic quiet;
		for (int i = 0; i < rsa_pkg::NUM_SLOTS; i++) begin
			cnt_tbl[PLAN_BOOK][rsa_pkg::idx_t'(i)] = '0;
			stk_tbl[PLAN_BOOK][rsa_pkg::idx_t'(i)] = '0;
			cnt_tbl[CHECK_BOOK][rsa_pkg::idx_t'(i)] = '0;
			stk_tbl[CHECK_BOOK][rsa_pkg::idx_t'(i)] = '0;
		end
		depth_tbl[PLAN_BOOK] = '0;
		occ_tbl[PLAN_BOOK] = '0;
		tok_tbl[PLAN_BOOK] = '0;
		depth_tbl[CHECK_BOOK] = '0;
		occ_tbl[CHECK_BOOK] = '0;
		tok_tbl[CHECK_BOOK] = '0;
		arst_n = 1'b0;

		// directed: empty removes, adds past fresh, stack pops, buried slots
		send(rsa_pkg::MODE_REMOVE, 8'd0, 1'b0);
		send(rsa_pkg::MODE_ADD, 8'd1, 1'b0);
		send(rsa_pkg::MODE_ADD, 8'd255, 1'b0);
		send(rsa_pkg::MODE_ADD, 8'd0, 1'b0);
		send(rsa_pkg::MODE_ADD, 8'd0, 1'b0);
		send(rsa_pkg::MODE_ADD, 8'd1, 1'b0);
		send(rsa_pkg::MODE_ADD, 8'd2, 1'b0);
		send(rsa_pkg::MODE_REMOVE, 8'd1, 1'b0);
		send(rsa_pkg::MODE_REMOVE, 8'd2, 1'b0);
		send(rsa_pkg::MODE_ADD, 8'd1, 1'b0);
		send(rsa_pkg::MODE_ADD, 8'd3, 1'b0);
		send(rsa_pkg::MODE_ADD, 8'd5, 1'b0);
		send(rsa_pkg::MODE_ADD, 8'd2, 1'b0);
		send(rsa_pkg::MODE_ADD, 8'd1, 1'b0);
		send(rsa_pkg::MODE_REMOVE, 8'd0, 1'b0);
		send(rsa_pkg::MODE_REMOVE, 8'd0, 1'b0);
		send(rsa_pkg::MODE_REMOVE, 8'd0, 1'b0);
		send(rsa_pkg::MODE_ADD, 8'd0, 1'b0);

		// open every slot, then empty them all onto the free stack
		while (occ_tbl[PLAN_BOOK] < rsa_pkg::NUM_SLOTS) begin
			if ($urandom_range(0, 4) == 0 && occ_tbl[PLAN_BOOK] != 0)
				send(rsa_pkg::MODE_ADD, find_slot(1'b1), 1'b0);
			else
				open_slot(1'b0);
		end
		send(rsa_pkg::MODE_ADD, 8'd255, 1'b0);
		while (occ_tbl[PLAN_BOOK] != 0)
			send(rsa_pkg::MODE_REMOVE, find_slot(1'b1), 1'b0);
		send(rsa_pkg::MODE_REMOVE, 8'd255, 1'b0);

		// random traffic in alternating grow and shrink stretches
		for (int blk = 0; blk < 10; blk++) begin
			quiet = ($urandom_range(0, 3) == 0);
			for (int i = 0; i < 95; i++)
				random_request(blk[0] == 1'b0, quiet);
		end

		repeat (9) @(posedge clk);
		arst_n <= 1'b1;

		while (pending_reqs.size() != 0 || have_req || req_ch.valid)
			@(posedge clk);
		while (due_results.size() != 0)
			@(posedge clk);
		repeat (20) @(posedge clk);

		$display("Checked %0d transactions: %0d rejected, %0d slot open/close events",
			n_results, n_rejected, n_opened);
		$display("Peak occupancy %0d slots, final token total %0d, %0d cycles",
			peak_occ, tok_tbl[CHECK_BOOK], cycles);
		if (mismatches == 0) begin
			$display("Testbench completed without errors");
		end else begin
			$display("%0d mismatches", mismatches);
			$display("Testbench completed WITH ERRORS");
		end
		$finish;
	end

endmodule

/* refcounted_slot_allocator.f */
hdl/rsa_pkg.sv
hdl/rsa_req_if.sv
hdl/rsa_rsp_if.sv
hdl/rsa_count_store.sv
hdl/rsa_free_stack.sv
hdl/refcounted_slot_allocator.sv
hdl/rsa_checker.sv
tb/tb_top.sv
